/* src/tlrp_pkg.sv */
// shared types and constants for the triggered led ramp pwm block
// no dependencies

package tlrp_pkg;

  localparam int CHANNELS    = 8;
  localparam int LEVEL_W     = 3;
  localparam int PORT_W      = 8;
  localparam int PINS_W      = 8;
  localparam int IDX_W       = 3;

  // ramp wraps to dark at this count, pwm phase runs modulo the period
  localparam int LEVEL_COUNT = 8;
  localparam int PWM_PERIOD  = 7;

  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [IDX_W-1:0]   chan_idx_t;

  // item kinds carried on tuser
  typedef enum logic [1:0] {
    ACT_RAMP   = 2'd0,
    ACT_PWM    = 2'd1,
    ACT_SAMPLE = 2'd2
  } action_t;

  // led to port bit routing
  localparam chan_idx_t LEFT_MAP  [CHANNELS] = '{3'd0, 3'd2, 3'd4, 3'd5, 3'd7, 3'd6, 3'd3, 3'd1};
  localparam chan_idx_t RIGHT_MAP [CHANNELS] = '{3'd7, 3'd5, 3'd3, 3'd2, 3'd0, 3'd1, 3'd4, 3'd6};

  localparam level_t LEVEL_LAST = level_t'(LEVEL_COUNT - 1);
  localparam level_t PHASE_LAST = level_t'(PWM_PERIOD - 1);

  // next ramp level: nonzero levels step up and wrap to zero
  function automatic level_t ramp_level(input level_t lv);
    level_t r;
    if (lv == '0) begin
      r = '0;
    end else if (lv == LEVEL_LAST) begin
      r = '0;
    end else begin
      r = lv + level_t'(1);
    end
    return r;
  endfunction

endpackage

/* src/triggered_led_ramp_pwm.sv */
// triggered led ramp pwm: top level, state update and registered result
// depends on tlrp_pkg
//
// the result is registered from the input transfer and is valid in the cycle after it
// throughput: one item per cycle while the result is taken; the result register frees as it is taken
// reset: synchronous active high; levels, phase, trigger lines and ports clear
// the output holds no valid result after reset

module triggered_led_ramp_pwm (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [tlrp_pkg::PINS_W-1:0] s_tdata,   // pins[7:0]
  input  logic [1:0]                  s_tuser,   // action[1:0]
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [2*tlrp_pkg::PORT_W-1:0] m_tdata  // left_port[7:0], right_port[15:8]
);
  import tlrp_pkg::*;

  level_t              left_levels  [CHANNELS];
  level_t              right_levels [CHANNELS];
  level_t              left_levels_next  [CHANNELS];
  level_t              right_levels_next [CHANNELS];
  level_t              pwm_phase, pwm_phase_next;
  logic                last_left_line, last_left_line_next;
  logic                last_right_line, last_right_line_next;
  logic [PORT_W-1:0]   left_port_reg, left_port_reg_next;
  logic [PORT_W-1:0]   right_port_reg, right_port_reg_next;
  logic                in_xfer;
  logic [PORT_W-1:0]   left_drive, right_drive;
  chan_idx_t           left_idx, right_idx;

  assign s_tready  = !m_tvalid || m_tready;
  assign in_xfer   = s_tvalid && s_tready;
  assign left_idx  = s_tdata[IDX_W-1:0];
  assign right_idx = s_tdata[2*IDX_W-1:IDX_W];

  // pwm compare per led, routed to its port bit
  always_comb begin
    left_drive  = '0;
    right_drive = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (left_levels[i] > pwm_phase) begin
        left_drive[LEFT_MAP[i]] = 1'b1;
      end
      if (right_levels[i] > pwm_phase) begin
        right_drive[RIGHT_MAP[i]] = 1'b1;
      end
    end
  end

  // next state for one item
  always_comb begin
    left_levels_next     = left_levels;
    right_levels_next    = right_levels;
    pwm_phase_next       = pwm_phase;
    last_left_line_next  = last_left_line;
    last_right_line_next = last_right_line;
    left_port_reg_next   = left_port_reg;
    right_port_reg_next  = right_port_reg;
    unique case (s_tuser)
      ACT_RAMP: begin
        for (int i = 0; i < CHANNELS; i++) begin
          left_levels_next[i]  = ramp_level(left_levels[i]);
          right_levels_next[i] = ramp_level(right_levels[i]);
        end
      end
      ACT_PWM: begin
        left_port_reg_next  = left_drive;
        right_port_reg_next = right_drive;
        pwm_phase_next      = (pwm_phase == PHASE_LAST) ? '0 : pwm_phase + level_t'(1);
      end
      ACT_SAMPLE: begin
        if (s_tdata[6] != last_right_line) begin
          right_levels_next[right_idx] = level_t'(1);
          last_right_line_next         = !last_right_line;
        end
        if (s_tdata[7] != last_left_line) begin
          left_levels_next[left_idx] = level_t'(1);
          last_left_line_next        = !last_left_line;
        end
      end
      default: begin
        // unused kind leaves all state alone
      end
    endcase
  end

  // state registers, updated on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        left_levels[i]  <= '0;
        right_levels[i] <= '0;
      end
      pwm_phase       <= '0;
      last_left_line  <= 1'b0;
      last_right_line <= 1'b0;
      left_port_reg   <= '0;
      right_port_reg  <= '0;
    end else if (in_xfer) begin
      left_levels     <= left_levels_next;
      right_levels    <= right_levels_next;
      pwm_phase       <= pwm_phase_next;
      last_left_line  <= last_left_line_next;
      last_right_line <= last_right_line_next;
      left_port_reg   <= left_port_reg_next;
      right_port_reg  <= right_port_reg_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_xfer) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      m_tdata <= {right_port_reg_next, left_port_reg_next};
    end
  end

  // checks
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while result stalled");

  a_xfer_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> m_tvalid)
    else $error("transfer produced no result");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    pwm_phase <= PHASE_LAST)
    else $error("pwm phase out of range");

  a_ramp_keeps_ports: assert property (@(posedge clk) disable iff (rst)
    in_xfer && s_tuser == ACT_RAMP |=> $stable(left_port_reg) && $stable(right_port_reg))
    else $error("ramp tick changed a port");

endmodule

/* tb/sv/testbench.sv */
// testbench for triggered_led_ramp_pwm: directed table, then random items under idling
// checks both port bytes against a local model; depends on tlrp_pkg and the block's rtl
`timescale 1ns / 100ps

module testbench;
  import tlrp_pkg::*;

  // code 3 is not an action, the block must ignore it
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam int DIRECTED_N    = 24;
  localparam int PHASE_ITEMS   = 300;
  localparam int PRESSURE_ITEMS = 130;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 8;

  // led to port bit routing, taken from the block's description
  localparam logic [2:0] LEFT_ROUTE  [8] = '{3'd0, 3'd2, 3'd4, 3'd5, 3'd7, 3'd6, 3'd3, 3'd1};
  localparam logic [2:0] RIGHT_ROUTE [8] = '{3'd7, 3'd5, 3'd3, 3'd2, 3'd0, 3'd1, 3'd4, 3'd6};

  typedef struct packed {
    logic [7:0] left_port;
    logic [7:0] right_port;
  } port_pair_t;

  typedef struct packed {
    logic [1:0] act;
    logic [7:0] pins;
    logic       typed;
    logic [7:0] left_port;
    logic [7:0] right_port;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // pins[7:0]
  logic [1:0]  s_tuser = '0;   // action[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // left_port[7:0], right_port[15:8]

  // local copy of the led state
  logic [2:0] left_level  [8];
  logic [2:0] right_level [8];
  logic [2:0] pwm_phase;
  logic       left_line, right_line;
  port_pair_t ports_now;

  port_pair_t port_expect_q [$];

  int error_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off_req = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  // ports still zero until a pwm tick sees a lit level
  stim_row_t directed_rows [DIRECTED_N] = '{
    '{ACT_PWM,    8'h00, 1'b1, 8'h00, 8'h00},
    '{ACT_RAMP,   8'h00, 1'b1, 8'h00, 8'h00},
    '{ACT_UNUSED, 8'hFF, 1'b1, 8'h00, 8'h00},
    '{ACT_SAMPLE, 8'hC0, 1'b1, 8'h00, 8'h00},
    '{ACT_SAMPLE, 8'hC0, 1'b1, 8'h00, 8'h00},
    '{ACT_SAMPLE, 8'h3F, 1'b1, 8'h00, 8'h00},
    '{ACT_PWM,    8'h00, 1'b0, 8'h00, 8'h00},
    '{ACT_RAMP,   8'h00, 1'b0, 8'h00, 8'h00},
    '{ACT_PWM,    8'h00, 1'b0, 8'h00, 8'h00},
    '{ACT_RAMP,   8'hFF, 1'b0, 8'h00, 8'h00},
    '{ACT_RAMP,   8'h00, 1'b0, 8'h00, 8'h00},
    '{ACT_PWM,    8'h00, 1'b0, 8'h00, 8'h00},
    '{ACT_RAMP,   8'h00, 1'b0, 8'h00, 8'h00},
    '{ACT_RAMP,   8'h00, 1'b0, 8'h00, 8'h00},
    '{ACT_PWM,    8'h00, 1'b0, 8'h00, 8'h00},
    '{ACT_RAMP,   8'h00, 1'b0, 8'h00, 8'h00},
    '{ACT_PWM,    8'h00, 1'b0, 8'h00, 8'h00},
    '{ACT_PWM,    8'h00, 1'b0, 8'h00, 8'h00},
    '{ACT_SAMPLE, 8'h85, 1'b0, 8'h00, 8'h00},
    '{ACT_SAMPLE, 8'h58, 1'b0, 8'h00, 8'h00},
    '{ACT_RAMP,   8'h00, 1'b0, 8'h00, 8'h00},
    '{ACT_PWM,    8'h00, 1'b0, 8'h00, 8'h00},
    '{ACT_PWM,    8'h00, 1'b0, 8'h00, 8'h00},
    '{ACT_UNUSED, 8'h00, 1'b0, 8'h00, 8'h00}
  };

  triggered_led_ramp_pwm u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // advance the led state by one item and return both port bytes
  function automatic port_pair_t next_ports(input logic [1:0] act, input logic [7:0] pins);
    case (act)
      ACT_RAMP: begin
        for (int i = 0; i < 8; i++) begin
          if (left_level[i] != 3'd0)
            left_level[i] = 3'((int'(left_level[i]) + 1) % LEVEL_COUNT);
          if (right_level[i] != 3'd0)
            right_level[i] = 3'((int'(right_level[i]) + 1) % LEVEL_COUNT);
        end
      end
      ACT_PWM: begin
        ports_now = '0;
        for (int i = 0; i < 8; i++) begin
          if (left_level[i] > pwm_phase) ports_now.left_port[LEFT_ROUTE[i]] = 1'b1;
          if (right_level[i] > pwm_phase) ports_now.right_port[RIGHT_ROUTE[i]] = 1'b1;
        end
        pwm_phase = 3'((int'(pwm_phase) + 1) % PWM_PERIOD);
      end
      ACT_SAMPLE: begin
        // a toggled trigger line arms its channel at level one
        if (pins[6] != right_line) begin
          right_level[pins[5:3]] = 3'd1;
          right_line = ~right_line;
        end
        if (pins[7] != left_line) begin
          left_level[pins[2:0]] = 3'd1;
          left_line = ~left_line;
        end
      end
      default: ;
    endcase
    return ports_now;
  endfunction

  // offer one item, with random idle cycles ahead of it, and wait for its transfer
  task automatic send_item(input logic [1:0] act, input logic [7:0] pins,
                           input logic typed, input port_pair_t typed_ports);
    port_pair_t predicted;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pins;
    s_tuser  <= act;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = next_ports(act, pins);
    port_expect_q.push_back(typed ? typed_ports : predicted);
  endtask

  task automatic send_random_item();
    int pick;
    logic [1:0] act;
    pick = $urandom_range(99);
    if (pick < 20)      act = ACT_RAMP;
    else if (pick < 60) act = ACT_PWM;
    else if (pick < 95) act = ACT_SAMPLE;
    else                act = ACT_UNUSED;
    send_item(act, 8'($urandom), 1'b0, '0);
  endtask

  // port byte check and receiver stalls
  always @(posedge clk) begin
    port_pair_t exp_ports;
    if (!rst && m_tvalid && m_tready) begin
      if (port_expect_q.size() == 0) begin
        $error("unexpected result transfer: left %h right %h", m_tdata[7:0], m_tdata[15:8]);
        error_count++;
      end else begin
        exp_ports = port_expect_q.pop_front();
        if (m_tdata[7:0] !== exp_ports.left_port) begin
          $error("left_port mismatch: expected %h actual %h", exp_ports.left_port, m_tdata[7:0]);
          error_count++;
        end
        if (m_tdata[15:8] !== exp_ports.right_port) begin
          $error("right_port mismatch: expected %h actual %h",
                 exp_ports.right_port, m_tdata[15:8]);
          error_count++;
        end
      end
    end
    if (hold_off_req) begin
      hold_left = HOLD_OFF_CYCLES;
      hold_off_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int send_pcts  [4];
    int stall_pcts [4];

    send_pcts  = '{0, 79, 0, 37};
    stall_pcts = '{0, 0, 79, 37};

    for (int i = 0; i < 8; i++) begin
      left_level[i]  = 3'd0;
      right_level[i] = 3'd0;
    end
    pwm_phase  = 3'd0;
    left_line  = 1'b0;
    right_line = 1'b0;
    ports_now  = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed items
    foreach (directed_rows[i])
      send_item(directed_rows[i].act, directed_rows[i].pins, directed_rows[i].typed,
                {directed_rows[i].left_port, directed_rows[i].right_port});

    // random items under each idling mix
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = send_pcts[p];
      recv_stall_pct = stall_pcts[p];
      repeat (PHASE_ITEMS) send_random_item();
    end

    // receiver holds off while the sender keeps offering, so the input backs up
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_req   = 1'b1;
    repeat (PRESSURE_ITEMS) send_random_item();
    s_tvalid <= 1'b0;

    while (port_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && port_expect_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
